FILE: src/cslru_pkg.sv
// ----------------------------------------------------------------------------
// cslru_pkg: shared types and constants
// Field widths, register indexes and the configuration bundle of the LRU
// cache lookup core.
// ----------------------------------------------------------------------------
package cslru_pkg;

   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int RANK_W     = 3;
   localparam int WAY_OUT_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAY_BITS    = 2'd2;

   // reset values of the registers
   localparam logic [3:0] OFFSET_BITS_RST = 4'd5;
   localparam logic [3:0] INDEX_BITS_RST  = 4'd10;
   localparam logic [1:0] WAY_BITS_RST    = 2'd0;

   typedef struct packed {
      logic [3:0] offset_bits;
      logic [3:0] index_bits;
      logic [1:0] way_bits;
   } cfg_type;

endpackage

FILE: src/set_assoc_cache_lru_lookup_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_core: set-associative cache hit/miss model, LRU
// Path: an address passes the request queue, the set row read registers and
//   the result register; the back end takes a new address only after the row
//   read then write-back, which waits while an unaccepted result is held.
// Reset: registers return to offset 5, index 10, way bits 0; a clearing pass
//   over all 2^max(1,floor(log2 SETS)) set rows then wipes valid bits and
//   ranks, and no address is taken until it ends. Tags are not cleared.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lookup_core #(
   parameter int SETS      = 1024,
   parameter int WAYS      = 8,
   parameter int ADDR_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cslru_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cslru_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // address requests
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cslru_pkg::ADDR_W-1:0]      req_address,
   // lookup results
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [cslru_pkg::WAY_OUT_W-1:0]   rsp_way
);
   import cslru_pkg::*;

   // Only whole powers of two of the sets and ways are ever addressed, so
   // the memories are sized to those. At most eight ways are usable since
   // way_bits tops out at 3.
   localparam int LOG_SETS = $clog2(SETS + 1) - 1;
   localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
   localparam int LOG_WAYS = $clog2(WAYS + 1) - 1;
   localparam int WAY_LOG  = (LOG_WAYS > 3) ? 3 : LOG_WAYS;

   cfg_type            cfg_ff, cfg_in;
   logic               init_done;
   logic               q_valid;
   logic               q_pop;
   logic [SET_W-1:0]   q_set;
   logic [TAG_W-1:0]   q_tag;

   // Config port never stalls; writes to an unused index are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OFFSET_BITS: cfg_in.offset_bits = csr_wdata;
            CSR_INDEX_BITS:  cfg_in.index_bits  = csr_wdata;
            CSR_WAY_BITS:    cfg_in.way_bits    = csr_wdata[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits <= OFFSET_BITS_RST;
         cfg_ff.index_bits  <= INDEX_BITS_RST;
         cfg_ff.way_bits    <= WAY_BITS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: decode the address into set/tag and queue it (two entries),
   // so a transfer is taken while the back end works on an earlier one.
   cslru_front #(
      .SETS      (SETS),
      .ADDR_BITS (ADDR_BITS),
      .SET_W     (SET_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .init_done   (init_done),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_set       (q_set),
      .q_tag       (q_tag)
   );

   // Back end: row read, compare/replace, write-back, result register.
   cslru_back #(
      .SET_W   (SET_W),
      .WAY_LOG (WAY_LOG)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .init_done (init_done),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_set     (q_set),
      .q_tag     (q_tag),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_hit   (rsp_hit),
      .rsp_way   (rsp_way)
   );

endmodule

FILE: src/cslru_front.sv
// ----------------------------------------------------------------------------
// cslru_front: address decode and request queue
// Splits each address into set index and tag, and holds up to two decoded
// requests for the back end.
// ----------------------------------------------------------------------------
module cslru_front #(
   parameter int SETS      = 1024,
   parameter int ADDR_BITS = 32,
   parameter int SET_W     = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cslru_pkg::cfg_type              cfg,
   input  logic                            init_done,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cslru_pkg::ADDR_W-1:0]    req_address,
   output logic                            q_valid,
   input  logic                            q_pop,
   output logic [SET_W-1:0]                q_set,
   output logic [cslru_pkg::TAG_W-1:0]     q_tag
);
   import cslru_pkg::*;

   localparam int LOG_SETS = $clog2(SETS + 1) - 1;
   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   logic [ADDR_W-1:0] addr_m;
   logic [ADDR_W-1:0] addr_sh;
   logic [4:0]        ib;
   logic [5:0]        tag_sh;
   logic [SET_W-1:0]  set_mask;
   logic [SET_W-1:0]  dec_set;
   logic [TAG_W-1:0]  dec_tag;

   logic [SET_W-1:0]  set_q_ff [2];
   logic [TAG_W-1:0]  tag_q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push;

   // effective index width: clipped to the sets that exist
   always_comb begin
      addr_m = req_address & ADDR_MASK;
      ib     = ({1'b0, cfg.index_bits} > 5'(LOG_SETS)) ? 5'(LOG_SETS)
                                                     : {1'b0, cfg.index_bits};
      addr_sh = addr_m >> cfg.offset_bits;
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = (5'(i) < ib);
      end
      dec_set = addr_sh[SET_W-1:0] & set_mask;
      tag_sh  = {2'b00, cfg.offset_bits} + {1'b0, ib};
      dec_tag = addr_m >> tag_sh;
   end

   assign req_ready = init_done && (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_set     = set_q_ff[rd_ptr_ff];
   assign q_tag     = tag_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         set_q_ff[wr_ptr_ff] <= dec_set;
         tag_q_ff[wr_ptr_ff] <= dec_tag;
      end
   end

endmodule

FILE: src/cslru_back.sv
// ----------------------------------------------------------------------------
// cslru_back: set lookup, LRU update and result register
// Reads one set row, compares tags, picks hit/fill/victim way, writes the
// row back and presents the result.
// ----------------------------------------------------------------------------
module cslru_back #(
   parameter int SET_W   = 10,
   parameter int WAY_LOG = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cslru_pkg::cfg_type                cfg,
   output logic                              init_done,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  logic [SET_W-1:0]                  q_set,
   input  logic [cslru_pkg::TAG_W-1:0]       q_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic [cslru_pkg::WAY_OUT_W-1:0]   rsp_way
);
   import cslru_pkg::*;

   localparam int SET_DEPTH = 1 << SET_W;
   localparam int UW        = 1 << WAY_LOG;
   localparam int WAY_W     = (WAY_LOG > 0) ? WAY_LOG : 1;

   typedef struct packed {
      logic              valid;
      logic [RANK_W-1:0] rank;
   } meta_type;

   typedef enum logic [1:0] {S_CLEAR, S_READ, S_EVAL} state_type;

   state_type                       state_ff;
   logic [SET_W-1:0]                clr_ff;
   logic [SET_W-1:0]                set_ff;
   logic [TAG_W-1:0]                tag_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_hit_ff;
   logic [WAY_OUT_W-1:0]            rsp_way_ff;

   logic [UW-1:0][TAG_W-1:0]        tag_mem [SET_DEPTH];
   meta_type [UW-1:0]               meta_mem [SET_DEPTH];
   logic [UW-1:0][TAG_W-1:0]        tag_rd_ff;
   meta_type [UW-1:0]               meta_rd_ff;

   logic                            rd_en;
   logic                            go;
   logic                            meta_we;
   logic [SET_W-1:0]                meta_waddr;
   meta_type [UW-1:0]               meta_wdata;
   logic                            tag_we;
   logic [UW-1:0][TAG_W-1:0]        tag_wdata;

   logic [1:0]                      wb;
   logic [3:0]                      nways;
   logic [UW-1:0]                   in_use;
   logic [UW-1:0]                   vld;
   logic                            found;
   logic [WAY_W-1:0]                hit_way;
   logic [3:0]                      count;
   logic                            found_free;
   logic [WAY_W-1:0]                free_way;
   logic [WAY_W-1:0]                lru_way;
   logic [RANK_W-1:0]               lru_rank;
   logic [WAY_W-1:0]                target;
   logic [RANK_W-1:0]               old_rank;
   meta_type [UW-1:0]               new_meta;
   logic [UW-1:0][TAG_W-1:0]        new_tags;

   assign init_done = (state_ff != S_CLEAR);
   assign rd_en     = (state_ff == S_READ) && q_valid;
   assign q_pop     = rd_en;
   assign go        = (state_ff == S_EVAL) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_way   = rsp_way_ff;

   // hit search, fill/victim choice and rank aging over the ways in use
   always_comb begin
      wb    = (cfg.way_bits > 2'(WAY_LOG)) ? 2'(WAY_LOG) : cfg.way_bits;
      nways = 4'd1 << wb;
      for (int w = 0; w < UW; w++) begin
         in_use[w] = (4'(w) < nways);
         vld[w]    = meta_rd_ff[w].valid && in_use[w];
      end

      found   = 1'b0;
      hit_way = '0;
      count   = '0;
      for (int w = 0; w < UW; w++) begin
         count = count + {3'b000, vld[w]};
         if (vld[w] && (tag_rd_ff[w] == tag_ff) && !found) begin
            found   = 1'b1;
            hit_way = WAY_W'(w);
         end
      end

      found_free = 1'b0;
      free_way   = '0;
      for (int w = 0; w < UW; w++) begin
         if (in_use[w] && !meta_rd_ff[w].valid && !found_free) begin
            found_free = 1'b1;
            free_way   = WAY_W'(w);
         end
      end

      // oldest way, lowest number wins a tie
      lru_way  = '0;
      lru_rank = meta_rd_ff[0].rank;
      for (int w = 1; w < UW; w++) begin
         if (in_use[w] && (meta_rd_ff[w].rank > lru_rank)) begin
            lru_rank = meta_rd_ff[w].rank;
            lru_way  = WAY_W'(w);
         end
      end

      if (found) begin
         target   = hit_way;
         old_rank = meta_rd_ff[hit_way].rank;
      end else if (count < nways) begin
         target   = free_way;
         old_rank = RANK_W'(count);
      end else begin
         target   = lru_way;
         old_rank = lru_rank;
      end

      new_meta = meta_rd_ff;
      new_tags = tag_rd_ff;
      for (int w = 0; w < UW; w++) begin
         if (WAY_W'(w) == target) begin
            new_meta[w].valid = 1'b1;
            new_meta[w].rank  = '0;
            new_tags[w]       = tag_ff;
         end else if (vld[w] && (meta_rd_ff[w].rank < old_rank)) begin
            new_meta[w].rank = meta_rd_ff[w].rank + 1'b1;
         end
      end
   end

   always_comb begin
      meta_we    = 1'b0;
      meta_waddr = set_ff;
      meta_wdata = new_meta;
      tag_we     = go && !found;
      tag_wdata  = new_tags;
      if (state_ff == S_CLEAR) begin
         meta_we    = 1'b1;
         meta_waddr = clr_ff;
         meta_wdata = '0;
      end else if (go) begin
         meta_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (rd_en) begin
         meta_rd_ff <= meta_mem[q_set];
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[set_ff] <= tag_wdata;
      end
      if (rd_en) begin
         tag_rd_ff <= tag_mem[q_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result in the same cycle keeps valid up
         if (rsp_valid_ff && rsp_ready && !go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SET_W'(SET_DEPTH - 1)) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (q_valid) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= found;
                  rsp_way_ff   <= WAY_OUT_W'(target);
                  state_ff     <= S_READ;
               end
            end
            default: begin
               state_ff <= S_READ;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         set_ff <= q_set;
         tag_ff <= q_tag;
      end
   end

endmodule
